@@ src/fstr_pkg.sv @@
// Shared types and constants for the frame/sample time rescale core.
`default_nettype none
package fstr_pkg;

  localparam int POS_W = 64;
  localparam int CFG_W = 32;
  localparam int HALF_W = POS_W / 2;
  localparam int DIV_STAGES = POS_W;

  localparam logic [POS_W-1:0] LIMIT_POS = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] LIMIT_NEG = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ROUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_FPS_NUM     = 2'd1,
    REG_FPS_DEN     = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_FRAME_TO_SAMPLE = 1'b0,
    CMD_SAMPLE_TO_FRAME = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  converted;
    status_t                  status;
  } out_t;

  typedef struct packed {
    logic             neg;
    status_t          status;
    logic [POS_W-1:0] den;
  } mul_ctl_t;

  typedef struct packed {
    logic             neg;
    status_t          status;
    logic [POS_W-1:0] den;
    logic [POS_W-1:0] rem;
    logic [POS_W-1:0] qlo;
  } div_word_t;

endpackage
`default_nettype wire

@@ src/fstr_mul.sv @@
// Four-stage 64x64 magnitude multiplier built from 32x32 partial products.
`default_nettype none
module fstr_mul
  import fstr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [POS_W-1:0] in_mag,
  input  wire logic [POS_W-1:0] in_num,
  input  wire mul_ctl_t         in_ctl,
  output logic                  out_valid,
  output div_word_t             out_word
);

  logic [3:0]               v_r;
  mul_ctl_t                 ctl1_r, ctl2_r, ctl3_r;
  logic [2*HALF_W-1:0]      p00_r, p01_r, p10_r, p11_r;
  logic [HALF_W+1:0]        mid_r, mid_nxt;
  logic [HALF_W-1:0]        lo32_r, p01h_r, p10h_r;
  logic [2*HALF_W-1:0]      p11b_r;
  logic [POS_W-1:0]         hi_r, hi_nxt, lo_r, lo_nxt;
  div_word_t                word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_comb begin
    mid_nxt = {2'b00, p00_r[2*HALF_W-1:HALF_W]} + {2'b00, p01_r[HALF_W-1:0]}
            + {2'b00, p10_r[HALF_W-1:0]};
    hi_nxt  = p11b_r + {{HALF_W{1'b0}}, p01h_r} + {{HALF_W{1'b0}}, p10h_r}
            + {{(POS_W-2){1'b0}}, mid_r[HALF_W+1:HALF_W]};
    lo_nxt  = {mid_r[HALF_W-1:0], lo32_r};
    word_nxt.neg = ctl3_r.neg;
    word_nxt.den = ctl3_r.den;
    word_nxt.rem = hi_r;
    word_nxt.qlo = lo_r;
    if (ctl3_r.status != ST_OK) begin
      word_nxt.status = ctl3_r.status;
    end else if (hi_r >= ctl3_r.den) begin
      word_nxt.status = ST_RANGE;
    end else begin
      word_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    p00_r  <= (2*HALF_W)'(in_mag[HALF_W-1:0]) * (2*HALF_W)'(in_num[HALF_W-1:0]);
    p01_r  <= (2*HALF_W)'(in_mag[HALF_W-1:0]) * (2*HALF_W)'(in_num[POS_W-1:HALF_W]);
    p10_r  <= (2*HALF_W)'(in_mag[POS_W-1:HALF_W]) * (2*HALF_W)'(in_num[HALF_W-1:0]);
    p11_r  <= (2*HALF_W)'(in_mag[POS_W-1:HALF_W]) * (2*HALF_W)'(in_num[POS_W-1:HALF_W]);
    ctl1_r <= in_ctl;
    mid_r  <= mid_nxt;
    lo32_r <= p00_r[HALF_W-1:0];
    p01h_r <= p01_r[2*HALF_W-1:HALF_W];
    p10h_r <= p10_r[2*HALF_W-1:HALF_W];
    p11b_r <= p11_r;
    ctl2_r <= ctl1_r;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    ctl3_r <= ctl2_r;
    word_r <= word_nxt;
  end

  assign out_valid = v_r[3];
  assign out_word  = word_r;

endmodule
`default_nettype wire

@@ src/fstr_div_stage.sv @@
// One restoring division step: one quotient bit per pipeline stage.
`default_nettype none
module fstr_div_stage
  import fstr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire div_word_t in_word,
  output logic           out_valid,
  output div_word_t      out_word
);

  logic            valid_r;
  div_word_t       word_r, word_nxt;
  logic [POS_W:0]  r_ext, diff;
  logic            ge;

  always_comb begin
    r_ext    = {in_word.rem, in_word.qlo[POS_W-1]};
    diff     = r_ext - {1'b0, in_word.den};
    ge       = ~diff[POS_W];
    word_nxt = in_word;
    word_nxt.rem = ge ? diff[POS_W-1:0] : r_ext[POS_W-1:0];
    word_nxt.qlo = {in_word.qlo[POS_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
`default_nettype wire

@@ src/fstr_round.sv @@
// Three-stage range check, round half away from zero and sign restore.
`default_nettype none
module fstr_round
  import fstr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire div_word_t in_word,
  output logic           out_valid,
  output out_t           out_data
);

  logic [2:0]        v_r;
  logic [POS_W-1:0]  limit, thr;
  status_t           st1_r, st1_nxt, st2_r;
  logic              neg1_r, neg2_r, up1_r, up_nxt;
  logic [POS_W-1:0]  q1_r, q2_r;
  out_t              out_r, out_nxt;

  always_comb begin
    limit = in_word.neg ? LIMIT_NEG : LIMIT_POS;
    thr   = {1'b0, in_word.den[POS_W-1:1]} + {{(POS_W-1){1'b0}}, in_word.den[0]};
    up_nxt = (in_word.rem >= thr);
    if (in_word.status != ST_OK) begin
      st1_nxt = in_word.status;
    end else if (in_word.qlo > limit) begin
      st1_nxt = ST_RANGE;
    end else if (up_nxt && (in_word.qlo == limit)) begin
      st1_nxt = ST_ROUND;
    end else begin
      st1_nxt = ST_OK;
    end
  end

  always_comb begin
    out_nxt.status = st2_r;
    if (st2_r != ST_OK) begin
      out_nxt.converted = '0;
    end else if (neg2_r) begin
      out_nxt.converted = {POS_W{1'b0}} - q2_r;
    end else begin
      out_nxt.converted = q2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st1_r  <= st1_nxt;
    neg1_r <= in_word.neg;
    up1_r  <= up_nxt;
    q1_r   <= in_word.qlo;
    st2_r  <= st1_r;
    neg2_r <= neg1_r;
    q2_r   <= q1_r + {{(POS_W-1){1'b0}}, up1_r};
    out_r  <= out_nxt;
  end

  assign out_valid = v_r[2];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/frame_sample_time_rescale_core.sv @@
// Frame/sample time rescale core top level.
// Accepted starts pass s0, s1, the multiplier, divider and round to out_valid.
// One transaction per cycle while busy is low; 64 of the stages are the divider.
// busy is high during reset and for the first cycle after it; no receiver stall.
// Reset restores sample_rate 48000, fps_numerator 30, fps_denominator 1.
`default_nettype none
module frame_sample_time_rescale_core
  import fstr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_t              in_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  out_valid,
  output out_t                  out_data
);

  logic [CFG_W-1:0] sample_rate_r, fps_num_r, fps_den_r;
  logic [POS_W-1:0] scale_r;
  logic             busy_r;
  logic             s0_valid_r, s1_valid_r;
  in_t              s0_data_r;
  logic [POS_W-1:0] s1_mag_r, s1_num_r, mag_nxt, num_nxt;
  mul_ctl_t         s1_ctl_r, ctl_nxt;
  logic             cfg_we;

  logic             div_v [0:DIV_STAGES];
  div_word_t        div_w [0:DIV_STAGES];

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= CFG_W'(48000);
      fps_num_r     <= CFG_W'(30);
      fps_den_r     <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data;
        REG_FPS_NUM:     fps_num_r     <= cfg_data;
        REG_FPS_DEN:     fps_den_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s0_valid_r <= start & ~busy_r;
      s1_valid_r <= s0_valid_r;
    end
  end

  always_comb begin
    ctl_nxt.neg = s0_data_r.position[POS_W-1];
    mag_nxt = ctl_nxt.neg ? ({POS_W{1'b0}} - s0_data_r.position) : s0_data_r.position;
    if (s0_data_r.command == CMD_FRAME_TO_SAMPLE) begin
      num_nxt     = scale_r;
      ctl_nxt.den = {{(POS_W-CFG_W){1'b0}}, fps_num_r};
    end else begin
      num_nxt     = {{(POS_W-CFG_W){1'b0}}, fps_num_r};
      ctl_nxt.den = scale_r;
    end
    if ((sample_rate_r == '0) || (fps_den_r == '0) || (fps_num_r == '0)) begin
      ctl_nxt.status = ST_ZERO;
    end else begin
      ctl_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    scale_r   <= POS_W'(sample_rate_r) * POS_W'(fps_den_r);
    s0_data_r <= in_data;
    s1_mag_r  <= mag_nxt;
    s1_num_r  <= num_nxt;
    s1_ctl_r  <= ctl_nxt;
  end

  fstr_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_mag    (s1_mag_r),
    .in_num    (s1_num_r),
    .in_ctl    (s1_ctl_r),
    .out_valid (div_v[0]),
    .out_word  (div_w[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fstr_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[g]),
      .in_word   (div_w[g]),
      .out_valid (div_v[g+1]),
      .out_word  (div_w[g+1])
    );
  end

  fstr_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_v[DIV_STAGES]),
    .in_word   (div_w[DIV_STAGES]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
